FILE: sv/fiba_pkg.sv
package fiba_pkg;

    // One row of the block used map holds this many block bits.
    localparam int ROW_W  = 32;
    localparam int ROW_BW = 5;

    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;
    localparam int BLOCK_W  = 9;
    localparam int TOTAL_W  = 10;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 10'd512;

    // After formatting, blocks 0 and 1 are taken.
    localparam logic [ROW_W-1:0] ROW0_INIT = 32'h0000_0003;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_CREATE = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NO_INODE  = 3'd3,
        ST_NO_BLOCK  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ISCAN,
        S_DECIDE,
        S_DEL_RD,
        S_DEL_WR,
        S_BSCAN,
        S_COMMIT,
        S_RESP
    } fsm_t;

    typedef struct packed {
        logic              found;
        logic [ROW_BW-1:0] bit_idx;
    } scan_t;

endpackage

FILE: sv/file_inode_and_block_allocator.sv
// Inode table with a free block map. Each item is one operation on file_id:
// lookup returns the in-use inode holding that id and its block; create
// takes the lowest unused inode and the lowest free block below
// min(total_blocks, BLOCK_COUNT), or reports that the id exists, that no
// inode is free or that no block is free, changing nothing on failure;
// delete frees the inode and its block or reports not found. Mode 3 answers
// not found. Every item gives exactly one result item. After reset the
// block runs a clearing pass over the used map, one row of 32 blocks per
// cycle, and takes no item meanwhile; total_blocks can be written at any
// idle time. The block works on one item at a time with one inode memory
// read port and one used map read port: the inode scan reads one inode per
// cycle over all INODE_COUNT inodes before the decision, a delete then
// reads and rewrites the used map row of the freed block, and a create
// that reaches the block search reads every row of the used map before it
// commits. The result sits in an output register until taken.
module file_inode_and_block_allocator #(
    parameter int INODE_COUNT = 16,
    parameter int BLOCK_COUNT = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [fiba_pkg::TOTAL_W-1:0]     cfg_wr_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_mode,
    input  logic [fiba_pkg::ID_W-1:0]        s_file_id,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [fiba_pkg::STATUS_W-1:0]    m_status,
    output logic [fiba_pkg::INDEX_W-1:0]     m_inode_index,
    output logic [fiba_pkg::BLOCK_W-1:0]     m_block_number
);

    localparam int IDX_W  = (INODE_COUNT > 1) ? $clog2(INODE_COUNT) : 1;
    localparam int IC_W   = $clog2(INODE_COUNT + 1);
    localparam int ROWS   = (BLOCK_COUNT + fiba_pkg::ROW_W - 1) / fiba_pkg::ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RC_W   = $clog2(ROWS + 1);
    localparam int BN_W   = ROW_AW + fiba_pkg::ROW_BW;
    localparam int CMP_W  = (ROW_AW + 6 > fiba_pkg::TOTAL_W) ? ROW_AW + 6
                                                             : fiba_pkg::TOTAL_W;
    localparam int IE_W   = fiba_pkg::ID_W + BN_W;

    fiba_pkg::fsm_t state_reg, state_next;

    // Configuration and item registers
    logic [fiba_pkg::TOTAL_W-1:0] total_reg;
    fiba_pkg::mode_t              mode_reg;
    logic [fiba_pkg::ID_W-1:0]    fid_reg;

    // Inode in-use bits live in flops so reset clears them at once
    logic [INODE_COUNT-1:0] in_use_reg;

    // Inode scan
    logic [IC_W-1:0]  icnt_reg;
    logic             ipend_reg;
    logic [IDX_W-1:0] iridx_reg;
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [BN_W-1:0]  hit_blk_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Block scan
    logic [RC_W-1:0]            bcnt_reg;
    logic                       bpend_reg;
    logic [ROW_AW-1:0]          brrow_reg;
    logic                       bfound_reg;
    logic [ROW_AW-1:0]          brow_reg;
    logic [fiba_pkg::ROW_BW-1:0] bbit_reg;
    logic [fiba_pkg::ROW_W-1:0] bdata_reg;

    logic [ROW_AW-1:0] clr_cnt_reg;

    // Staged result and output register
    fiba_pkg::status_t             res_status_reg;
    logic [IDX_W-1:0]              res_idx_reg;
    logic [BN_W-1:0]               res_blk_reg;
    logic                          m_valid_reg;
    logic [fiba_pkg::STATUS_W-1:0] m_status_reg;
    logic [fiba_pkg::INDEX_W-1:0]  m_inode_index_reg;
    logic [fiba_pkg::BLOCK_W-1:0]  m_block_number_reg;

    // Memory ports
    logic                       iram_we, iram_re;
    logic [IDX_W-1:0]           iram_waddr, iram_raddr;
    logic [IE_W-1:0]            iram_wdata, iram_rdata;
    logic                       uram_we, uram_re;
    logic [ROW_AW-1:0]          uram_waddr, uram_raddr;
    logic [fiba_pkg::ROW_W-1:0] uram_wdata, uram_rdata;

    logic [fiba_pkg::ID_W-1:0] rd_id;
    logic [BN_W-1:0]           rd_blk;
    logic [CMP_W-1:0]          tb_ext;
    logic [CMP_W-1:0]          limit;
    fiba_pkg::scan_t           scan;
    logic                      out_free;
    logic                      iscan_last;
    logic                      bscan_last;
    logic [ROW_AW-1:0]         hit_row;
    logic [fiba_pkg::ROW_BW-1:0] hit_bit;
    logic [IDX_W+fiba_pkg::INDEX_W-1:0] idx_pad;
    logic [BN_W+fiba_pkg::BLOCK_W-1:0]  blk_pad;

    assign rd_id   = iram_rdata[IE_W-1:BN_W];
    assign rd_blk  = iram_rdata[BN_W-1:0];
    assign hit_row = hit_blk_reg[BN_W-1:fiba_pkg::ROW_BW];
    assign hit_bit = hit_blk_reg[fiba_pkg::ROW_BW-1:0];

    // Clamp the block limit to what the map holds
    assign tb_ext = CMP_W'(total_reg);
    assign limit  = (tb_ext > CMP_W'(BLOCK_COUNT)) ? CMP_W'(BLOCK_COUNT) : tb_ext;

    assign out_free   = !m_valid_reg || m_ready;
    assign iscan_last = ipend_reg && (iridx_reg == IDX_W'(INODE_COUNT - 1));
    assign bscan_last = bpend_reg && (brrow_reg == ROW_AW'(ROWS - 1));

    assign idx_pad = {{fiba_pkg::INDEX_W{1'b0}}, res_idx_reg};
    assign blk_pad = {{fiba_pkg::BLOCK_W{1'b0}}, res_blk_reg};

    fiba_ram #(
        .WIDTH (IE_W),
        .DEPTH (INODE_COUNT)
    ) u_inode_ram (
        .aclk    (aclk),
        .wr_en   (iram_we),
        .wr_addr (iram_waddr),
        .wr_data (iram_wdata),
        .rd_en   (iram_re),
        .rd_addr (iram_raddr),
        .rd_data (iram_rdata)
    );

    fiba_ram #(
        .WIDTH (fiba_pkg::ROW_W),
        .DEPTH (ROWS)
    ) u_used_ram (
        .aclk    (aclk),
        .wr_en   (uram_we),
        .wr_addr (uram_waddr),
        .wr_data (uram_wdata),
        .rd_en   (uram_re),
        .rd_addr (uram_raddr),
        .rd_data (uram_rdata)
    );

    fiba_row_scan #(
        .ROW_AW (ROW_AW),
        .CMP_W  (CMP_W)
    ) u_row_scan (
        .row_data (uram_rdata),
        .row_idx  (brrow_reg),
        .limit    (limit),
        .scan     (scan)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fiba_pkg::S_CLEAR: begin
                if (clr_cnt_reg == ROW_AW'(ROWS - 1)) begin
                    state_next = fiba_pkg::S_IDLE;
                end
            end
            fiba_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = fiba_pkg::S_ISCAN;
                end
            end
            fiba_pkg::S_ISCAN: begin
                if (iscan_last) begin
                    state_next = fiba_pkg::S_DECIDE;
                end
            end
            fiba_pkg::S_DECIDE: begin
                case (mode_reg)
                    fiba_pkg::MODE_DELETE: begin
                        state_next = hit_found_reg ? fiba_pkg::S_DEL_RD
                                                   : fiba_pkg::S_RESP;
                    end
                    fiba_pkg::MODE_CREATE: begin
                        state_next = (!hit_found_reg && free_found_reg)
                                     ? fiba_pkg::S_BSCAN : fiba_pkg::S_RESP;
                    end
                    default: begin
                        state_next = fiba_pkg::S_RESP;
                    end
                endcase
            end
            fiba_pkg::S_DEL_RD: begin
                state_next = fiba_pkg::S_DEL_WR;
            end
            fiba_pkg::S_DEL_WR: begin
                state_next = fiba_pkg::S_RESP;
            end
            fiba_pkg::S_BSCAN: begin
                if (bscan_last) begin
                    state_next = fiba_pkg::S_COMMIT;
                end
            end
            fiba_pkg::S_COMMIT: begin
                state_next = fiba_pkg::S_RESP;
            end
            fiba_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = fiba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fiba_pkg::S_CLEAR;
            end
        endcase
    end

    // Memory controls and handshake
    always_comb begin
        s_ready    = 1'b0;
        iram_re    = 1'b0;
        iram_raddr = icnt_reg[IDX_W-1:0];
        iram_we    = 1'b0;
        iram_waddr = free_idx_reg;
        iram_wdata = {fid_reg, brow_reg, bbit_reg};
        uram_re    = 1'b0;
        uram_raddr = bcnt_reg[ROW_AW-1:0];
        uram_we    = 1'b0;
        uram_waddr = clr_cnt_reg;
        uram_wdata = (clr_cnt_reg == '0) ? fiba_pkg::ROW0_INIT : '0;
        case (state_reg)
            fiba_pkg::S_CLEAR: begin
                uram_we = 1'b1;
            end
            fiba_pkg::S_IDLE: begin
                s_ready = 1'b1;
            end
            fiba_pkg::S_ISCAN: begin
                iram_re = (icnt_reg < IC_W'(INODE_COUNT));
            end
            fiba_pkg::S_DEL_RD: begin
                uram_re    = 1'b1;
                uram_raddr = hit_row;
            end
            fiba_pkg::S_DEL_WR: begin
                uram_we    = 1'b1;
                uram_waddr = hit_row;
                uram_wdata = uram_rdata & ~(fiba_pkg::ROW_W'(1) << hit_bit);
            end
            fiba_pkg::S_BSCAN: begin
                uram_re = (bcnt_reg < RC_W'(ROWS));
            end
            fiba_pkg::S_COMMIT: begin
                iram_we    = bfound_reg;
                uram_we    = bfound_reg;
                uram_waddr = brow_reg;
                uram_wdata = bdata_reg;
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fiba_pkg::S_CLEAR;
            clr_cnt_reg <= '0;
            total_reg   <= fiba_pkg::TOTAL_RESET;
            in_use_reg  <= '0;
            m_valid_reg <= 1'b0;
            ipend_reg   <= 1'b0;
            bpend_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                total_reg <= cfg_wr_data;
            end
            if (state_reg == fiba_pkg::S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ROW_AW'(1);
            end
            ipend_reg <= (state_reg == fiba_pkg::S_ISCAN) && iram_re;
            bpend_reg <= (state_reg == fiba_pkg::S_BSCAN) && uram_re;
            if (state_reg == fiba_pkg::S_DEL_WR) begin
                in_use_reg[hit_idx_reg] <= 1'b0;
            end
            if (state_reg == fiba_pkg::S_COMMIT && bfound_reg) begin
                in_use_reg[free_idx_reg] <= 1'b1;
            end
            if (state_reg == fiba_pkg::S_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            fiba_pkg::S_IDLE: begin
                mode_reg       <= fiba_pkg::mode_t'(s_mode);
                fid_reg        <= s_file_id;
                icnt_reg       <= '0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            fiba_pkg::S_ISCAN: begin
                if (iram_re) begin
                    icnt_reg  <= icnt_reg + IC_W'(1);
                    iridx_reg <= icnt_reg[IDX_W-1:0];
                end
                if (ipend_reg) begin
                    // Keep the lowest matching and the lowest unused inode
                    if (in_use_reg[iridx_reg] && rd_id == fid_reg && !hit_found_reg) begin
                        hit_found_reg <= 1'b1;
                        hit_idx_reg   <= iridx_reg;
                        hit_blk_reg   <= rd_blk;
                    end
                    if (!in_use_reg[iridx_reg] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= iridx_reg;
                    end
                end
            end
            fiba_pkg::S_DECIDE: begin
                bcnt_reg       <= '0;
                bfound_reg     <= 1'b0;
                res_status_reg <= fiba_pkg::ST_NOT_FOUND;
                res_idx_reg    <= '0;
                res_blk_reg    <= '0;
                case (mode_reg)
                    fiba_pkg::MODE_LOOKUP, fiba_pkg::MODE_DELETE: begin
                        if (hit_found_reg) begin
                            res_status_reg <= fiba_pkg::ST_OK;
                            res_idx_reg    <= hit_idx_reg;
                            res_blk_reg    <= hit_blk_reg;
                        end
                    end
                    fiba_pkg::MODE_CREATE: begin
                        if (hit_found_reg) begin
                            res_status_reg <= fiba_pkg::ST_EXISTS;
                        end else if (!free_found_reg) begin
                            res_status_reg <= fiba_pkg::ST_NO_INODE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            fiba_pkg::S_BSCAN: begin
                if (uram_re) begin
                    bcnt_reg  <= bcnt_reg + RC_W'(1);
                    brrow_reg <= bcnt_reg[ROW_AW-1:0];
                end
                if (bpend_reg && scan.found && !bfound_reg) begin
                    bfound_reg <= 1'b1;
                    brow_reg   <= brrow_reg;
                    bbit_reg   <= scan.bit_idx;
                    bdata_reg  <= uram_rdata | (fiba_pkg::ROW_W'(1) << scan.bit_idx);
                end
            end
            fiba_pkg::S_COMMIT: begin
                if (bfound_reg) begin
                    res_status_reg <= fiba_pkg::ST_OK;
                    res_idx_reg    <= free_idx_reg;
                    res_blk_reg    <= {brow_reg, bbit_reg};
                end else begin
                    res_status_reg <= fiba_pkg::ST_NO_BLOCK;
                end
            end
            fiba_pkg::S_RESP: begin
                if (out_free) begin
                    m_status_reg       <= res_status_reg;
                    m_inode_index_reg  <= idx_pad[fiba_pkg::INDEX_W-1:0];
                    m_block_number_reg <= blk_pad[fiba_pkg::BLOCK_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_inode_index  = m_inode_index_reg;
    assign m_block_number = m_block_number_reg;

    // An accepted item blocks the input until its result is loaded into the output register
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready while an item is in progress");

    // A result only appears out of the response state
    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == fiba_pkg::S_RESP))
        else $error("result raised outside the response state");

    // Create only commits into an inode that is still unused
    a_commit_free_inode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fiba_pkg::S_COMMIT && bfound_reg) |-> !in_use_reg[free_idx_reg])
        else $error("create commits into an inode in use");

    // Failed operations report zero index and block
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != fiba_pkg::ST_OK) |->
            (m_inode_index == '0 && m_block_number == '0))
        else $error("failed result carries nonzero index or block");

    // A delete only frees an inode that matched and is in use
    a_hit_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fiba_pkg::S_DEL_WR) |-> (hit_found_reg && in_use_reg[hit_idx_reg]))
        else $error("delete of an inode not in use");

endmodule

FILE: sv/fiba_ram.sv
module fiba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/fiba_row_scan.sv
// Find the lowest free block in one row of the used map, below the block limit.
module fiba_row_scan #(
    parameter int ROW_AW = 4,
    parameter int CMP_W  = 10
) (
    input  logic [fiba_pkg::ROW_W-1:0] row_data,
    input  logic [ROW_AW-1:0]          row_idx,
    input  logic [CMP_W-1:0]           limit,
    output fiba_pkg::scan_t            scan
);

    logic [CMP_W-1:0]          base;
    logic [CMP_W-1:0]          diff;
    logic [fiba_pkg::ROW_W-1:0] lim_mask;
    logic [fiba_pkg::ROW_W-1:0] free_bits;

    assign base = CMP_W'({row_idx, {fiba_pkg::ROW_BW{1'b0}}});
    assign diff = limit - base;

    always_comb begin
        if (limit <= base) begin
            lim_mask = '0;
        end else if (diff >= CMP_W'(fiba_pkg::ROW_W)) begin
            lim_mask = '1;
        end else begin
            lim_mask = (fiba_pkg::ROW_W'(1) << diff[fiba_pkg::ROW_BW-1:0])
                       - fiba_pkg::ROW_W'(1);
        end
    end

    assign free_bits = ~row_data & lim_mask;

    // Walk down so the lowest free bit wins.
    always_comb begin
        scan = '0;
        for (int b = fiba_pkg::ROW_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                scan.found   = 1'b1;
                scan.bit_idx = fiba_pkg::ROW_BW'(b);
            end
        end
    end

endmodule
